/* rtl/core/ddo_pkg.sv */
// Shared types, constants and tables for the differential drive odometry block.
// No dependencies; every other file uses these through scoped names.
package ddo_pkg;

  localparam int ROT_W        = 16;
  localparam int RAD_W        = 16;
  localparam int AXLE_W       = 20;
  localparam int ANG_W        = 32;
  localparam int CS_W         = 34;
  localparam int MUL_W        = 32;
  localparam int DIV_N_W      = 64;
  localparam int DIV_D_W      = 34;
  localparam int MR_A_W       = 49;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int ATAN_ENTRIES = 24;

  localparam int POS_WIDTH_DEF    = 32;
  localparam int ANGLE_WIDTH_DEF  = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic [RAD_W-1:0]  RADIUS_RESET = 16'd3277;
  localparam logic [AXLE_W-1:0] AXLE_RESET   = 20'd19661;
  localparam logic [MUL_W-1:0]  INV_TWO_PI   = 32'd683565276;
  localparam logic signed [CS_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AXLE   = 2'd1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DL,
    ST_DR,
    ST_CS0,
    ST_CS0_WAIT,
    ST_W_MUL,
    ST_W_DIV,
    ST_W_WAIT,
    ST_R_MUL,
    ST_R_DIV,
    ST_R_WAIT,
    ST_CS1,
    ST_CS1_WAIT,
    ST_MR_HI,
    ST_MR_LO,
    ST_MR_FIN,
    ST_OUT
  } state_e;

  // atan(2^-i) in 32-bit binary angle units
  function automatic logic [ANG_W-1:0] atan_unit(input logic [4:0] idx);
    logic [ANG_W-1:0] v;
    unique case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/ddo_if.sv */
// Valid/ready channel interfaces for wheel samples, pose results and config writes.
// Depends on ddo_pkg for field widths.
interface ddo_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ddo_pkg::ROT_W-1:0]      left_rotation;
  logic signed [ddo_pkg::ROT_W-1:0]      right_rotation;
  modport source(output valid, left_rotation, right_rotation, input ready);
  modport sink(input valid, left_rotation, right_rotation, output ready);
endinterface

interface ddo_out_if #(
  parameter int POS_WIDTH   = ddo_pkg::POS_WIDTH_DEF,
  parameter int ANGLE_WIDTH = ddo_pkg::ANGLE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [POS_WIDTH-1:0]   pose_x;
  logic signed [POS_WIDTH-1:0]   pose_y;
  logic [ANGLE_WIDTH-1:0]        heading;
  modport source(output valid, pose_x, pose_y, heading, input ready);
  modport sink(input valid, pose_x, pose_y, heading, output ready);
endinterface

interface ddo_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ddo_pkg::CFG_IDX_W-1:0]     index;
  logic [ddo_pkg::CFG_DATA_W-1:0]    data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* rtl/core/ddo_mul.sv */
// Shared unsigned 32x32 multiplier with a registered product.
// Depends on ddo_pkg for operand width.
module ddo_mul (
  input  logic                          clk_i,
  input  logic [ddo_pkg::MUL_W-1:0]     a_i,
  input  logic [ddo_pkg::MUL_W-1:0]     b_i,
  output logic [2*ddo_pkg::MUL_W-1:0]   prod_o
);

  logic [2*ddo_pkg::MUL_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

/* rtl/core/ddo_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on ddo_pkg for dividend and divisor widths.
module ddo_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ddo_pkg::DIV_N_W-1:0]   dividend_i,
  input  logic [ddo_pkg::DIV_D_W-1:0]   divisor_i,
  output logic                          done_o,
  output logic [ddo_pkg::DIV_N_W-1:0]   quot_o
);

  localparam int NW = ddo_pkg::DIV_N_W;
  localparam int DW = ddo_pkg::DIV_D_W;
  localparam int CW = $clog2(NW);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] num_q;
  logic [DW-1:0] rem_q, div_q;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem_q, num_q[NW-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NW-2:0], fits};
      rem_q <= fits ? DW'(trial - {1'b0, div_q}) : trial[DW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

/* rtl/core/ddo_cordic.sv */
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, with quadrant fold.
// Depends on ddo_pkg for the arctangent table and datapath widths.
module ddo_cordic #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [ddo_pkg::ANG_W-1:0]         angle_i,
  output logic                              done_o,
  output logic signed [ddo_pkg::CS_W-1:0]   cos_o,
  output logic signed [ddo_pkg::CS_W-1:0]   sin_o
);

  localparam int AW = ddo_pkg::ANG_W;
  localparam int SW = ddo_pkg::CS_W;
  localparam int CW = $clog2(CORDIC_STEPS);

  logic                 busy_q, done_q;
  logic [CW-1:0]        cnt_q;
  logic signed [SW-1:0] x_q, y_q, z_q;
  logic [1:0]           quad_q;
  logic [AW-1:0]        a_pre;
  logic signed [SW-1:0] dx, dy, at;

  assign a_pre = angle_i + 32'h2000_0000;
  assign dx    = y_q >>> cnt_q;
  assign dy    = x_q >>> cnt_q;
  assign at    = SW'(signed'({1'b0, ddo_pkg::atan_unit(5'(cnt_q))}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quad_q <= a_pre[AW-1:AW-2];
      x_q    <= ddo_pkg::CORDIC_GAIN;
      y_q    <= '0;
      z_q    <= SW'(signed'({1'b0, a_pre[AW-3:0]})) - SW'(signed'(33'h0_2000_0000));
    end else if (busy_q) begin
      if (!z_q[SW-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end
  end

  // fold the result back to its quadrant
  always_comb begin
    unique case (quad_q)
      2'd0: begin cos_o = x_q;  sin_o = y_q;  end
      2'd1: begin cos_o = -y_q; sin_o = x_q;  end
      2'd2: begin cos_o = -x_q; sin_o = -y_q; end
      default: begin cos_o = y_q; sin_o = -x_q; end
    endcase
  end

  assign done_o = done_q;

endmodule

/* rtl/core/diff_drive_odometry.sv */
// Differential drive odometry: one pose update per wheel sample, one request at a time.
// When both wheels travel alike, a result takes one CORDIC pass; when turning, it takes
// two passes of the shared divider and two CORDIC passes. A new request is accepted only
// in the idle state, after the output handshake of the previous result completes.
// Reset clears the pose to zero, loads the default radius and axle, and empties the output.
// Depends on ddo_pkg, ddo_if, ddo_mul, ddo_div, ddo_cordic.
module diff_drive_odometry #(
  parameter int POS_WIDTH    = ddo_pkg::POS_WIDTH_DEF,
  parameter int ANGLE_WIDTH  = ddo_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  ddo_in_if.sink   in_i,
  ddo_cfg_if.sink  cfg_i,
  ddo_out_if.source out_o
);

  localparam int PW    = POS_WIDTH;
  localparam int HW    = ANGLE_WIDTH;
  localparam int ACC_W = PW + 3;
  localparam int MW    = ddo_pkg::MUL_W;
  localparam int SW    = ddo_pkg::CS_W;
  localparam int AW    = ddo_pkg::ANG_W;
  localparam int AXW   = ddo_pkg::AXLE_W;
  localparam int RW    = ddo_pkg::ROT_W;
  localparam int NA    = ddo_pkg::MR_A_W;
  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'((64'sd1 <<< (PW - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_MAX - ACC_W'(1);
  localparam logic [AW:0] H_ROUND = (AW + 1)'(1) << (AW - 1 - HW);

  ddo_pkg::state_e state_q, state_d;

  // configuration
  logic [ddo_pkg::RAD_W-1:0] radius_q;
  logic [AXW-1:0]            axle_q;

  // pose and working registers
  logic signed [PW-1:0]    pos_x_q, pos_y_q;
  logic [HW-1:0]           head_q;
  logic signed [ACC_W-1:0] acc_x_q, acc_y_q;
  logic signed [RW-1:0]    rl_q, rr_q;
  logic signed [31:0]      dl_q, dr_q;
  logic signed [SW-1:0]    c0_q, s0_q, c1_q, s1_q;
  logic [AW-1:0]           w_q;
  logic signed [PW-1:0]    rc_q;
  logic                    turn_q;
  logic [1:0]              k_q;
  logic [63:0]             phi_q;
  logic                    out_valid_q;

  // shared units
  logic [MW-1:0]   mul_a, mul_b;
  logic [2*MW-1:0] prod;
  logic            div_start, div_done;
  logic [63:0]     div_num, quot;
  logic [ddo_pkg::DIV_D_W-1:0] div_den;
  logic            cs_start, cs_done;
  logic [AW-1:0]   cs_angle;
  logic signed [SW-1:0] cs_cos, cs_sin;

  ddo_mul u_mul (.clk_i, .a_i(mul_a), .b_i(mul_b), .prod_o(prod));

  ddo_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_num),
    .divisor_i(div_den), .done_o(div_done), .quot_o(quot)
  );

  ddo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni, .start_i(cs_start), .angle_i(cs_angle),
    .done_o(cs_done), .cos_o(cs_cos), .sin_o(cs_sin)
  );

  // derived quantities
  logic signed [32:0] d_diff, d_sum;
  logic [31:0]        md, msum;
  logic [AXW-1:0]     ax;
  logic [31:0]        den;
  logic [AW-1:0]      th;
  logic [15:0]        rl_mag, rr_mag;

  assign d_diff = 33'(dr_q) - 33'(dl_q);
  assign d_sum  = 33'(dl_q) + 33'(dr_q);
  assign md     = d_diff[32] ? 32'(-d_diff) : d_diff[31:0];
  assign msum   = d_sum[32] ? 32'(-d_sum) : d_sum[31:0];
  assign ax     = (axle_q == '0) ? AXW'(1) : axle_q;
  assign den    = {ax, 12'b0};
  assign th     = {head_q, {(AW - HW){1'b0}}};
  assign rl_mag = rl_q[RW-1] ? 16'(-rl_q) : rl_q;
  assign rr_mag = rr_q[RW-1] ? 16'(-rr_q) : rr_q;

  // rounded product terms: a is dl when straight, the ICR radius otherwise
  logic signed [NA-1:0] a_sel, a_mag;
  logic signed [SW-1:0] b_sel, b_mag;
  logic                 to_y, sub_term, term_neg;
  logic [63:0]          q_lo, t_sum, m_val;
  logic signed [ACC_W-1:0] term;

  always_comb begin
    a_sel = turn_q ? NA'(rc_q) : NA'(dl_q);
    if (!turn_q) begin
      b_sel    = k_q[0] ? s0_q : c0_q;
      to_y     = k_q[0];
      sub_term = 1'b0;
    end else begin
      unique case (k_q)
        2'd0: b_sel = s0_q;
        2'd1: b_sel = s1_q;
        2'd2: b_sel = c0_q;
        default: b_sel = c1_q;
      endcase
      to_y     = k_q[1];
      sub_term = (k_q == 2'd0) || (k_q == 2'd3);
    end
  end

  assign a_mag    = a_sel[NA-1] ? -a_sel : a_sel;
  assign b_mag    = b_sel[SW-1] ? -b_sel : b_sel;
  assign term_neg = a_sel[NA-1] ^ b_sel[SW-1] ^ sub_term;
  assign q_lo     = prod + (turn_q ? (64'd1 << 29) : (64'd1 << 41));
  assign t_sum    = phi_q + (q_lo >> 24);
  assign m_val    = turn_q ? (t_sum >> 6) : (t_sum >> 18);
  assign term     = term_neg ? -signed'(m_val[ACC_W-1:0]) : signed'(m_val[ACC_W-1:0]);

  logic last_term;
  assign last_term = turn_q ? (k_q == 2'd3) : (k_q == 2'd1);

  // next accumulator values with the term of the finishing product
  logic signed [ACC_W-1:0] nx, ny;
  assign nx = to_y ? acc_x_q : acc_x_q + term;
  assign ny = to_y ? acc_y_q + term : acc_y_q;

  function automatic logic signed [PW-1:0] sat(input logic signed [ACC_W-1:0] v);
    logic signed [PW-1:0] r;
    if (v > ACC_MAX)      r = ACC_MAX[PW-1:0];
    else if (v < ACC_MIN) r = ACC_MIN[PW-1:0];
    else                  r = v[PW-1:0];
    return r;
  endfunction

  // heading step: omega rounded to the stored angle width
  logic [AW:0] h_inc;
  assign h_inc = ({1'b0, w_q} + H_ROUND) >> (AW - HW);

  // ICR radius with sign and saturation
  logic          rc_neg, rq_big;
  logic [PW-1:0] rq_lo;
  assign rc_neg = d_sum[32] != d_diff[32];
  assign rq_big = |quot[63:PW-1];
  assign rq_lo  = quot[PW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ddo_pkg::ST_IDLE:     if (in_i.valid) state_d = ddo_pkg::ST_DL;
      ddo_pkg::ST_DL:       state_d = ddo_pkg::ST_DR;
      ddo_pkg::ST_DR:       state_d = ddo_pkg::ST_CS0;
      ddo_pkg::ST_CS0:      state_d = ddo_pkg::ST_CS0_WAIT;
      ddo_pkg::ST_CS0_WAIT: if (cs_done) begin
        state_d = (dl_q == dr_q) ? ddo_pkg::ST_MR_HI : ddo_pkg::ST_W_MUL;
      end
      ddo_pkg::ST_W_MUL:    state_d = ddo_pkg::ST_W_DIV;
      ddo_pkg::ST_W_DIV:    state_d = ddo_pkg::ST_W_WAIT;
      ddo_pkg::ST_W_WAIT:   if (div_done) state_d = ddo_pkg::ST_R_MUL;
      ddo_pkg::ST_R_MUL:    state_d = ddo_pkg::ST_R_DIV;
      ddo_pkg::ST_R_DIV:    state_d = ddo_pkg::ST_R_WAIT;
      ddo_pkg::ST_R_WAIT:   if (div_done) state_d = ddo_pkg::ST_CS1;
      ddo_pkg::ST_CS1:      state_d = ddo_pkg::ST_CS1_WAIT;
      ddo_pkg::ST_CS1_WAIT: if (cs_done) state_d = ddo_pkg::ST_MR_HI;
      ddo_pkg::ST_MR_HI:    state_d = ddo_pkg::ST_MR_LO;
      ddo_pkg::ST_MR_LO:    state_d = ddo_pkg::ST_MR_FIN;
      ddo_pkg::ST_MR_FIN:   state_d = last_term ? ddo_pkg::ST_OUT : ddo_pkg::ST_MR_HI;
      ddo_pkg::ST_OUT:      if (out_o.ready) state_d = ddo_pkg::ST_IDLE;
      default:              state_d = ddo_pkg::ST_IDLE;
    endcase
  end

  // unit controls
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    cs_start  = 1'b0;
    cs_angle  = th;
    unique case (state_q)
      ddo_pkg::ST_DL:    begin mul_a = MW'(rl_mag); mul_b = MW'(radius_q); end
      ddo_pkg::ST_DR:    begin mul_a = MW'(rr_mag); mul_b = MW'(radius_q); end
      ddo_pkg::ST_CS0:   cs_start = 1'b1;
      ddo_pkg::ST_W_MUL: begin mul_a = md; mul_b = ddo_pkg::INV_TWO_PI; end
      ddo_pkg::ST_W_DIV: begin
        div_start = 1'b1;
        div_num   = prod + 64'(den >> 1);
        div_den   = ddo_pkg::DIV_D_W'(den);
      end
      ddo_pkg::ST_R_MUL: begin mul_a = MW'(ax); mul_b = msum; end
      ddo_pkg::ST_R_DIV: begin
        div_start = 1'b1;
        div_num   = prod + 64'(md);
        div_den   = ddo_pkg::DIV_D_W'({md, 1'b0});
      end
      ddo_pkg::ST_CS1: begin
        cs_start = 1'b1;
        cs_angle = th + w_q;
      end
      ddo_pkg::ST_MR_HI: begin
        mul_a = MW'(a_mag[NA-2:24]);
        mul_b = b_mag[MW-1:0];
      end
      ddo_pkg::ST_MR_LO: begin
        mul_a = MW'(a_mag[23:0]);
        mul_b = b_mag[MW-1:0];
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ddo_pkg::ST_IDLE;
      radius_q    <= ddo_pkg::RADIUS_RESET;
      axle_q      <= ddo_pkg::AXLE_RESET;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        if (cfg_i.index == ddo_pkg::CFG_RADIUS) radius_q <= cfg_i.data[ddo_pkg::RAD_W-1:0];
        if (cfg_i.index == ddo_pkg::CFG_AXLE)   axle_q   <= cfg_i.data[AXW-1:0];
      end
      if (state_q == ddo_pkg::ST_IDLE) k_q <= '0;
      if (state_q == ddo_pkg::ST_MR_FIN) begin
        k_q <= k_q + 2'd1;
        if (last_term) begin
          // commit the new pose and raise the result
          pos_x_q     <= sat(nx);
          pos_y_q     <= sat(ny);
          if (turn_q) head_q <= head_q + h_inc[HW-1:0];
          out_valid_q <= 1'b1;
        end
      end
      if (out_valid_q && out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ddo_pkg::ST_IDLE: if (in_i.valid) begin
        rl_q    <= in_i.left_rotation;
        rr_q    <= in_i.right_rotation;
        acc_x_q <= ACC_W'(pos_x_q);
        acc_y_q <= ACC_W'(pos_y_q);
      end
      ddo_pkg::ST_DR:  dl_q <= rl_q[RW-1] ? -signed'(prod[31:0]) : signed'(prod[31:0]);
      ddo_pkg::ST_CS0: dr_q <= rr_q[RW-1] ? -signed'(prod[31:0]) : signed'(prod[31:0]);
      ddo_pkg::ST_CS0_WAIT: if (cs_done) begin
        c0_q   <= cs_cos;
        s0_q   <= cs_sin;
        turn_q <= dl_q != dr_q;
      end
      ddo_pkg::ST_W_WAIT: if (div_done) begin
        w_q <= d_diff[32] ? -quot[AW-1:0] : quot[AW-1:0];
      end
      ddo_pkg::ST_R_WAIT: if (div_done) begin
        if (rc_neg) rc_q <= rq_big ? ACC_MIN[PW-1:0] : -signed'(rq_lo);
        else        rc_q <= rq_big ? ACC_MAX[PW-1:0] : signed'(rq_lo);
      end
      ddo_pkg::ST_CS1_WAIT: if (cs_done) begin
        c1_q <= cs_cos;
        s1_q <= cs_sin;
      end
      ddo_pkg::ST_MR_LO: phi_q <= prod;
      ddo_pkg::ST_MR_FIN: begin
        acc_x_q <= nx;
        acc_y_q <= ny;
      end
      default: ;
    endcase
  end

  assign in_i.ready    = (state_q == ddo_pkg::ST_IDLE);
  assign cfg_i.ready   = 1'b1;
  assign out_o.valid   = out_valid_q;
  assign out_o.pose_x  = pos_x_q;
  assign out_o.pose_y  = pos_y_q;
  assign out_o.heading = head_q;

endmodule
